/* sv/plps_pkg.sv */
// ----------------------------------------------------------------------------
// plps_pkg
// Shared types and codes for the lookahead point search block.
// ----------------------------------------------------------------------------
package plps_pkg;

    localparam int COORD_W   = 24;
    localparam int LIMIT_W   = 16;
    localparam int NEXT_W    = 10;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int POINT_W   = 2 * COORD_W;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MODE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_GT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR    = 2'd2;

    localparam logic [LIMIT_W-1:0] NEAR_RST = 16'd128;
    localparam logic [LIMIT_W-1:0] FAR_RST  = 16'd512;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

endpackage

/* sv/plps_ram.sv */
// ----------------------------------------------------------------------------
// plps_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module plps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/path_lookahead_point_search_top.sv */
// ----------------------------------------------------------------------------
// path_lookahead_point_search_top
// Stores an estimated and a ground-truth path and searches the selected one
// for the lowest point whose distance from the vehicle lies between limits.
//
//   channel   | handshake           | payload
//   ----------+---------------------+------------------------------------------
//   request   | start / busy        | i_action, i_path_select, i_coord_x/y,
//             |                     | i_last_point, i_follow_on
//   result    | o_strobe (1 cycle)  | o_look_x/y, o_used_position,
//             |                     | o_next_index, o_overflow
//   config    | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// Loads, mode changes and queries that return the position leave busy low.
// A searching query keeps busy high for one RAM read per entry from the search
// start down to entry 1, then three pipeline stages (difference, square,
// compare) and a final update of the state.
// The result strobe is registered and rises in the cycle after the request
// completes; the receiver cannot stall. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module path_lookahead_point_search_top #(
    parameter int PATH_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [plps_pkg::ACT_W-1:0]          i_action,
    input  logic                                i_path_select,
    input  logic signed [plps_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [plps_pkg::COORD_W-1:0] i_coord_y,
    input  logic                                i_last_point,
    input  logic                                i_follow_on,
    output logic                                o_strobe,
    output logic signed [plps_pkg::COORD_W-1:0] o_look_x,
    output logic signed [plps_pkg::COORD_W-1:0] o_look_y,
    output logic                                o_used_position,
    output logic [plps_pkg::NEXT_W-1:0]         o_next_index,
    output logic                                o_overflow,
    input  logic                                i_cfg_we,
    input  logic [plps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [plps_pkg::LIMIT_W-1:0]        i_cfg_data
);

    import plps_pkg::*;

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int FW = AW + 1;
    localparam logic [FW-1:0] DEPTH_F = FW'(PATH_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // configuration
    logic                 r_use_gt;
    logic [LIMIT_W-1:0]   r_near;
    logic [LIMIT_W-1:0]   r_far;
    logic [2*LIMIT_W-1:0] r_lo;
    logic [2*LIMIT_W-1:0] r_hi;

    // path state
    logic          r_following;
    logic          r_overflow;
    logic          r_held  [2];
    logic [FW-1:0] r_fill  [2];
    logic [AW-1:0] r_start [2];
    t_point        r_look;

    // sequencer
    logic          r_state;
    logic          r_qsel;
    logic          r_issue;
    logic [AW-1:0] r_addr;
    logic          r_v1;
    logic          r_v2;
    logic          r_v3;
    logic          r_hit;
    logic [AW-1:0] r_best;
    t_point        r_best_pt;

    // datapath
    t_coord             r_qx;
    t_coord             r_qy;
    logic [AW-1:0]      r_i1;
    logic [AW-1:0]      r_i2;
    logic [AW-1:0]      r_i3;
    t_point             r_pt2;
    t_point             r_pt3;
    logic signed [COORD_W:0] r_dx;
    logic signed [COORD_W:0] r_dy;
    logic [2*COORD_W+1:0] r_sx;
    logic [2*COORD_W+1:0] r_sy;

    // result
    logic              r_strobe;
    logic              r_out_used;
    logic [NEXT_W-1:0] r_out_next;
    logic              r_out_ovf;

    logic                 w_accept;
    logic                 w_psel;
    logic [FW-1:0]        w_fill;
    logic [AW-1:0]        w_start;
    logic                 w_held;
    logic                 w_room;
    logic [FW-1:0]        w_newfill;
    logic [AW-1:0]        w_lock_start;
    logic                 w_load;
    logic                 w_wr;
    logic                 w_scan;
    logic                 w_fin;
    logic [FW-1:0]        w_nx;
    logic [FW-1:0]        w_lastix;
    logic [AW-1:0]        w_clamp;
    logic [AW-1:0]        w_fin_start;
    logic [AW+NEXT_W-1:0] w_start_ext;
    logic [AW+NEXT_W-1:0] w_fin_ext;
    logic [AW-1:0]        w_ram_addr;
    logic [POINT_W-1:0]   w_wdata;
    logic [POINT_W-1:0]   w_est_rdata;
    logic [POINT_W-1:0]   w_truth_rdata;
    t_point               w_rdata;
    logic [2*COORD_W+1:0] w_d2;
    logic                 w_hit3;

    assign busy     = (r_state == S_SCAN);
    assign w_accept = start && !busy;

    assign w_psel = busy ? r_qsel :
                    ((i_action == ACT_LOAD) ? i_path_select : r_use_gt);
    assign w_fill  = r_fill[w_psel];
    assign w_start = r_start[w_psel];
    assign w_held  = r_held[w_psel];

    assign w_room       = (w_fill < DEPTH_F);
    assign w_newfill    = w_room ? (w_fill + FW'(1)) : w_fill;
    assign w_lock_start = (w_newfill != '0) ? AW'(w_newfill - FW'(1)) : '0;
    assign w_load = w_accept && (i_action == ACT_LOAD) && r_following && !w_held;
    assign w_wr   = w_load && w_room;
    assign w_scan = w_held && (w_start != '0) && (w_fill != '0);

    assign w_fin       = busy && !r_issue && !r_v1 && !r_v2 && !r_v3;
    assign w_nx        = FW'(r_best) + FW'(1);
    assign w_lastix    = w_fill - FW'(1);
    assign w_clamp     = (w_nx > w_lastix) ? AW'(w_lastix) : AW'(w_nx);
    assign w_fin_start = r_hit ? w_clamp : w_start;
    assign w_start_ext = (AW + NEXT_W)'(w_start);
    assign w_fin_ext   = (AW + NEXT_W)'(w_fin_start);

    assign w_ram_addr = busy ? r_addr : AW'(w_fill);
    assign w_wdata    = {i_coord_x, i_coord_y};

    plps_ram #(
        .WIDTH(POINT_W),
        .DEPTH(PATH_DEPTH)
    ) u_est_ram (
        .i_clk  (i_clk),
        .i_we   (w_wr && !i_path_select),
        .i_addr (w_ram_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_est_rdata)
    );

    plps_ram #(
        .WIDTH(POINT_W),
        .DEPTH(PATH_DEPTH)
    ) u_truth_ram (
        .i_clk  (i_clk),
        .i_we   (w_wr && i_path_select),
        .i_addr (w_ram_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_truth_rdata)
    );

    assign w_rdata = r_qsel ? w_truth_rdata : w_est_rdata;
    assign w_d2    = r_sx + r_sy;
    assign w_hit3  = (w_d2 > (2*COORD_W+2)'(r_lo)) && (w_d2 < (2*COORD_W+2)'(r_hi));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_gt    <= 1'b0;
            r_near      <= NEAR_RST;
            r_far       <= FAR_RST;
            r_lo        <= '0;
            r_hi        <= '0;
            r_following <= 1'b0;
            r_overflow  <= 1'b0;
            r_held[0]   <= 1'b0;
            r_held[1]   <= 1'b0;
            r_fill[0]   <= '0;
            r_fill[1]   <= '0;
            r_start[0]  <= '0;
            r_start[1]  <= '0;
            r_look      <= '0;
            r_state     <= S_IDLE;
            r_qsel      <= 1'b0;
            r_issue     <= 1'b0;
            r_addr      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_hit       <= 1'b0;
            r_best      <= '0;
            r_best_pt   <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= (w_accept && (i_action == ACT_QUERY) && !w_scan) || w_fin;
            r_lo     <= r_near * r_near;
            r_hi     <= r_far * r_far;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_USE_GT: r_use_gt <= i_cfg_data[0];
                    CFG_NEAR:   r_near   <= i_cfg_data;
                    CFG_FAR:    r_far    <= i_cfg_data;
                    default:    ;
                endcase
            end

            if (w_accept) begin
                case (i_action)
                    ACT_LOAD: begin
                        if (w_load) begin
                            r_fill[w_psel] <= w_newfill;
                            if (!w_room) begin
                                r_overflow <= 1'b1;
                            end
                            if (i_last_point) begin
                                r_held[w_psel]  <= 1'b1;
                                r_start[w_psel] <= w_lock_start;
                            end
                        end
                    end
                    ACT_MODE: begin
                        if (i_follow_on) begin
                            r_following <= 1'b1;
                        end else begin
                            r_following <= 1'b0;
                            r_overflow  <= 1'b0;
                            r_held[0]   <= 1'b0;
                            r_held[1]   <= 1'b0;
                            r_fill[0]   <= '0;
                            r_fill[1]   <= '0;
                            r_start[0]  <= '0;
                            r_start[1]  <= '0;
                        end
                    end
                    ACT_QUERY: begin
                        if (w_scan) begin
                            r_state <= S_SCAN;
                            r_qsel  <= r_use_gt;
                            r_issue <= 1'b1;
                            r_addr  <= w_start;
                            r_hit   <= 1'b0;
                        end else begin
                            r_look <= {i_coord_x, i_coord_y};
                        end
                    end
                    default: ;
                endcase
            end

            // scan pipeline: read, difference, square, compare
            r_v1 <= r_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_issue) begin
                if (r_addr == AW'(1)) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr - AW'(1);
                end
            end
            if (r_v3 && w_hit3) begin
                r_hit     <= 1'b1;
                r_best    <= r_i3;
                r_best_pt <= r_pt3;
            end

            if (w_fin) begin
                r_state <= S_IDLE;
                if (r_hit) begin
                    r_look          <= r_best_pt;
                    r_start[r_qsel] <= w_clamp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
        end
        r_i1  <= r_addr;
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_pt2 <= w_rdata;
        r_pt3 <= r_pt2;
        r_dx  <= {r_qx[COORD_W-1], r_qx} - {w_rdata.x[COORD_W-1], w_rdata.x};
        r_dy  <= {r_qy[COORD_W-1], r_qy} - {w_rdata.y[COORD_W-1], w_rdata.y};
        r_sx  <= (2*COORD_W+2)'(r_dx * r_dx);
        r_sy  <= (2*COORD_W+2)'(r_dy * r_dy);

        if (w_accept && (i_action == ACT_QUERY) && !w_scan) begin
            r_out_used <= 1'b1;
            r_out_next <= w_start_ext[NEXT_W-1:0];
            r_out_ovf  <= r_overflow;
        end else if (w_fin) begin
            r_out_used <= 1'b0;
            r_out_next <= w_fin_ext[NEXT_W-1:0];
            r_out_ovf  <= r_overflow;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_look_x        = r_look.x;
    assign o_look_y        = r_look.y;
    assign o_used_position = r_out_used;
    assign o_next_index    = r_out_next;
    assign o_overflow      = r_out_ovf;

endmodule

/* sim/plps_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plps_checker
// Watches the request, config and result ports of the lookahead point search
// block, keeps its own copy of both paths and the search state, predicts the
// result of every accepted query and compares it field by field.
// ----------------------------------------------------------------------------
module plps_checker #(
    parameter int PATH_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [plps_pkg::ACT_W-1:0]          i_action,
    input  logic                                i_path_select,
    input  logic signed [plps_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [plps_pkg::COORD_W-1:0] i_coord_y,
    input  logic                                i_last_point,
    input  logic                                i_follow_on,
    input  logic                                o_strobe,
    input  logic signed [plps_pkg::COORD_W-1:0] o_look_x,
    input  logic signed [plps_pkg::COORD_W-1:0] o_look_y,
    input  logic                                o_used_position,
    input  logic [plps_pkg::NEXT_W-1:0]         o_next_index,
    input  logic                                o_overflow,
    input  logic                                i_cfg_we,
    input  logic [plps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [plps_pkg::LIMIT_W-1:0]        i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import plps_pkg::*;

    localparam int IDX_W  = $clog2(PATH_DEPTH);
    localparam int FILL_W = IDX_W + 1;

    typedef struct packed {
        t_coord             x;
        t_coord             y;
        logic               used;
        logic [NEXT_W-1:0]  next_idx;
        logic               ovf;
    } t_lookahead;

    t_lookahead         lookahead_q[$];
    t_point             route [2][PATH_DEPTH];
    logic [FILL_W-1:0]  fill_cnt [2];
    logic [IDX_W-1:0]   search_idx [2];
    logic               path_held [2];
    logic               follow_en;
    t_point             look_pt;
    logic               ovf_flag;
    logic               use_gt;
    logic [LIMIT_W-1:0] near_lim;
    logic [LIMIT_W-1:0] far_lim;
    int                 n_fail = 0;

    function automatic void clear_paths();
        for (int s = 0; s < 2; s++) begin
            fill_cnt[s]   = '0;
            search_idx[s] = '0;
            path_held[s]  = 1'b0;
        end
        ovf_flag = 1'b0;
    endfunction

    function automatic t_lookahead search_lookahead(input t_coord cx, input t_coord cy);
        t_lookahead  res;
        int          sel;
        int unsigned top_idx;
        int unsigned best;
        logic        hit;
        longint      dx;
        longint      dy;
        longint      d2;
        longint      lo;
        longint      hi;
        sel      = use_gt ? 1 : 0;
        res.used = 1'b0;
        if (path_held[sel] && search_idx[sel] != 0 && fill_cnt[sel] != 0) begin
            lo      = longint'(near_lim) * longint'(near_lim);
            hi      = longint'(far_lim) * longint'(far_lim);
            top_idx = (search_idx[sel] < fill_cnt[sel]) ? search_idx[sel] : fill_cnt[sel] - 1;
            hit     = 1'b0;
            best    = 0;
            // scan downward so the lowest matching entry wins
            for (int i = top_idx; i > 0; i--) begin
                dx = longint'(cx) - longint'(route[sel][i].x);
                dy = longint'(cy) - longint'(route[sel][i].y);
                d2 = dx * dx + dy * dy;
                if (d2 > lo && d2 < hi) begin
                    hit  = 1'b1;
                    best = i;
                end
            end
            if (hit) begin
                look_pt         = route[sel][best];
                search_idx[sel] = IDX_W'((best + 1 > fill_cnt[sel] - 1) ?
                                         fill_cnt[sel] - 1 : best + 1);
            end
        end else begin
            look_pt  = '{x: cx, y: cy};
            res.used = 1'b1;
        end
        res.x        = look_pt.x;
        res.y        = look_pt.y;
        res.next_idx = NEXT_W'(search_idx[sel]);
        res.ovf      = ovf_flag;
        return res;
    endfunction

    function automatic void check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_lookahead want;
        int         sel;
        if (!i_rst_n) begin
            clear_paths();
            follow_en = 1'b0;
            look_pt   = '0;
            use_gt    = 1'b0;
            near_lim  = NEAR_RST;
            far_lim   = FAR_RST;
            lookahead_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_USE_GT: use_gt   = i_cfg_data[0];
                    CFG_NEAR:   near_lim = i_cfg_data;
                    CFG_FAR:    far_lim  = i_cfg_data;
                    default: ;
                endcase
            end

            if (o_strobe) begin
                if (lookahead_q.size() == 0) begin
                    $error("result with no request pending: look_x %0d look_y %0d",
                           o_look_x, o_look_y);
                    n_fail++;
                end else begin
                    want = lookahead_q.pop_front();
                    check_field("look_x", longint'(want.x), longint'(o_look_x));
                    check_field("look_y", longint'(want.y), longint'(o_look_y));
                    check_field("used_position", want.used, o_used_position);
                    check_field("next_index", want.next_idx, o_next_index);
                    check_field("overflow", want.ovf, o_overflow);
                end
            end

            if (start && !busy) begin
                case (i_action)
                    ACT_LOAD: begin
                        sel = i_path_select ? 1 : 0;
                        if (follow_en && !path_held[sel]) begin
                            if (fill_cnt[sel] < PATH_DEPTH) begin
                                route[sel][fill_cnt[sel]] = '{x: i_coord_x, y: i_coord_y};
                                fill_cnt[sel]++;
                            end else begin
                                ovf_flag = 1'b1;
                            end
                            if (i_last_point) begin
                                path_held[sel]  = 1'b1;
                                search_idx[sel] = (fill_cnt[sel] != '0) ?
                                                  IDX_W'(fill_cnt[sel] - FILL_W'(1)) : '0;
                            end
                        end
                    end
                    ACT_QUERY: lookahead_q = {lookahead_q,
                                              search_lookahead(i_coord_x, i_coord_y)};
                    ACT_MODE: begin
                        if (i_follow_on) begin
                            follow_en = 1'b1;
                        end else begin
                            follow_en = 1'b0;
                            clear_paths();
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending    <= lookahead_q.size();
        o_fail_count <= n_fail;
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives path loads, following-mode changes and lookahead queries into the
// lookahead point search block: a directed opening, then random paths with
// queries placed around them, noise and broken loads, under several limit
// settings and sender idle rates. A checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import plps_pkg::*;

    localparam int                   DEPTH       = 1024;
    localparam int                   CYCLE_LIMIT = 4000000;
    localparam int                   ITEM_TARGET = 565;
    localparam logic [ACT_W-1:0]     ACT_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 start           = 1'b0;
    logic                 busy;
    logic [ACT_W-1:0]     i_action        = ACT_LOAD;
    logic                 i_path_select   = 1'b0;
    t_coord               i_coord_x       = '0;
    t_coord               i_coord_y       = '0;
    logic                 i_last_point    = 1'b0;
    logic                 i_follow_on     = 1'b0;
    logic                 o_strobe;
    t_coord               o_look_x;
    t_coord               o_look_y;
    logic                 o_used_position;
    logic [NEXT_W-1:0]    o_next_index;
    logic                 o_overflow;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx       = CFG_USE_GT;
    logic [LIMIT_W-1:0]   i_cfg_data      = '0;

    int                   fail_total;
    int                   pending_cnt;
    int unsigned          cycle_cnt       = 0;

    int                   n_sent          = 0;
    int                   gap_pct         = 0;
    int                   gap_levels [3]  = '{0, 77, 23};
    logic                 cur_use_gt      = 1'b0;
    logic [LIMIT_W-1:0]   cur_far         = FAR_RST;
    t_point               est_trail [$];
    t_point               gt_trail [$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    path_lookahead_point_search_top #(
        .PATH_DEPTH(DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_path_select   (i_path_select),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_last_point    (i_last_point),
        .i_follow_on     (i_follow_on),
        .o_strobe        (o_strobe),
        .o_look_x        (o_look_x),
        .o_look_y        (o_look_y),
        .o_used_position (o_used_position),
        .o_next_index    (o_next_index),
        .o_overflow      (o_overflow),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    plps_checker #(
        .PATH_DEPTH(DEPTH)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_path_select   (i_path_select),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_last_point    (i_last_point),
        .i_follow_on     (i_follow_on),
        .o_strobe        (o_strobe),
        .o_look_x        (o_look_x),
        .o_look_y        (o_look_y),
        .o_used_position (o_used_position),
        .o_next_index    (o_next_index),
        .o_overflow      (o_overflow),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_total),
        .o_pending       (pending_cnt)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // start is left high after acceptance; the next request or a drain follows
    // in the same time step
    task automatic issue(input logic [ACT_W-1:0] act, input logic sel, input t_coord x,
                         input t_coord y, input logic last, input logic fon);
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_path_select <= sel;
        i_coord_x     <= x;
        i_coord_y     <= y;
        i_last_point  <= last;
        i_follow_on   <= fon;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic gt, input logic [LIMIT_W-1:0] near_v,
                             input logic [LIMIT_W-1:0] far_v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_USE_GT;
        i_cfg_data <= {15'($urandom), gt};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_NEAR;
        i_cfg_data <= near_v;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FAR;
        i_cfg_data <= far_v;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_use_gt = gt;
        cur_far    = far_v;
    endtask

    task automatic send_route(input logic sel, input int len, input logic close);
        t_coord px;
        t_coord py;
        t_point pt;
        px = t_coord'(int'($urandom_range(0, 14000000)) - 7000000);
        py = t_coord'(int'($urandom_range(0, 14000000)) - 7000000);
        if (sel) gt_trail.delete();
        else est_trail.delete();
        for (int n = 0; n < len; n++) begin
            px = px + t_coord'(int'($urandom_range(0, 600)) - 300);
            py = py + t_coord'(int'($urandom_range(0, 600)) - 300);
            issue(ACT_LOAD, sel, px, py, close && n == len - 1, 1'($urandom));
            if (n < DEPTH) begin
                pt = '{x: px, y: py};
                if (sel) gt_trail = {gt_trail, pt};
                else est_trail = {est_trail, pt};
            end
        end
    endtask

    task automatic send_queries(input int k);
        t_point anchor;
        int     mag;
        for (int q = 0; q < k; q++) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 2))
                    0: issue(ACT_SPARE, 1'($urandom), t_coord'($urandom), t_coord'($urandom),
                             1'($urandom), 1'($urandom));
                    1: issue(ACT_LOAD, 1'($urandom), t_coord'($urandom), t_coord'($urandom),
                             1'($urandom), 1'($urandom));
                    default: issue(ACT_QUERY, 1'($urandom), t_coord'($urandom),
                                   t_coord'($urandom), 1'($urandom), 1'($urandom));
                endcase
            end else begin
                if (cur_use_gt && gt_trail.size() != 0)
                    anchor = gt_trail[$urandom_range(0, gt_trail.size() - 1)];
                else if (!cur_use_gt && est_trail.size() != 0)
                    anchor = est_trail[$urandom_range(0, est_trail.size() - 1)];
                else
                    anchor = '{x: t_coord'($urandom), y: t_coord'($urandom)};
                mag = int'(cur_far) + 64;
                issue(ACT_QUERY, 1'($urandom),
                      anchor.x + t_coord'(int'($urandom_range(0, 2 * mag)) - mag),
                      anchor.y + t_coord'(int'($urandom_range(0, 2 * mag)) - mag),
                      1'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        int ep;
        int cfg_step;
        int len;
        ep       = 0;
        cfg_step = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        issue(ACT_QUERY, 1'b1, t_coord'(8388607), t_coord'(-8388608), 1'b1, 1'b1);
        issue(ACT_LOAD, 1'b0, t_coord'(1), t_coord'(2), 1'b1, 1'b1);
        issue(ACT_SPARE, 1'b1, t_coord'(-1), t_coord'(-1), 1'b1, 1'b1);
        issue(ACT_MODE, 1'b0, '0, '0, 1'b0, 1'b1);
        issue(ACT_LOAD, 1'b0, t_coord'(0), t_coord'(0), 1'b0, 1'b0);
        issue(ACT_LOAD, 1'b0, t_coord'(256), t_coord'(0), 1'b0, 1'b0);
        issue(ACT_LOAD, 1'b0, t_coord'(512), t_coord'(0), 1'b0, 1'b0);
        issue(ACT_LOAD, 1'b0, t_coord'(768), t_coord'(0), 1'b1, 1'b0);
        issue(ACT_LOAD, 1'b0, t_coord'(9), t_coord'(9), 1'b1, 1'b0);
        issue(ACT_QUERY, 1'b0, t_coord'(0), t_coord'(0), 1'b0, 1'b0);
        issue(ACT_QUERY, 1'b0, t_coord'(1000), t_coord'(0), 1'b0, 1'b0);
        issue(ACT_QUERY, 1'b0, t_coord'(5000), t_coord'(5000), 1'b0, 1'b0);
        issue(ACT_LOAD, 1'b1, t_coord'(8388607), t_coord'(8388607), 1'b0, 1'b1);
        issue(ACT_LOAD, 1'b1, t_coord'(-8388608), t_coord'(-8388608), 1'b1, 1'b1);
        configure(1'b1, 16'd0, 16'hFFFF);
        issue(ACT_QUERY, 1'b0, t_coord'(-8388608), t_coord'(-8388508), 1'b0, 1'b0);
        issue(ACT_QUERY, 1'b0, t_coord'(8388607), t_coord'(-8388608), 1'b0, 1'b0);
        issue(ACT_MODE, 1'b1, '0, '0, 1'b1, 1'b0);
        issue(ACT_QUERY, 1'b0, t_coord'(-77), t_coord'(77), 1'b0, 1'b0);
        issue(ACT_MODE, 1'b0, '0, '0, 1'b0, 1'b1);
        issue(ACT_LOAD, 1'b1, t_coord'(100), t_coord'(-100), 1'b1, 1'b0);
        issue(ACT_QUERY, 1'b1, t_coord'(100), t_coord'(-100), 1'b1, 1'b1);

        // random episodes: load one or both paths, then query around them
        while (n_sent < ITEM_TARGET) begin
            ep++;
            if (ep % 2 == 0) gap_pct = gap_levels[(ep / 2) % 3];
            if (ep % 3 == 0) begin
                case (cfg_step % 5)
                    0: configure(1'b0, 16'hFFFF, 16'hFFFF);
                    1: configure(1'b1, 16'd0, 16'd0);
                    2: configure(1'($urandom), 16'($urandom_range(0, 400)),
                                 16'($urandom_range(401, 2000)));
                    3: configure(1'b1, 16'd0, 16'hFFFF);
                    default: configure(1'b0, NEAR_RST, FAR_RST);
                endcase
                cfg_step++;
            end
            if ($urandom_range(0, 1) == 0)
                issue(ACT_MODE, 1'($urandom), t_coord'($urandom), t_coord'($urandom),
                      1'($urandom), 1'b0);
            issue(ACT_MODE, 1'($urandom), t_coord'($urandom), t_coord'($urandom),
                  1'($urandom), 1'b1);
            if (ep == 4 || ep == 11) begin
                // full store, and one load running past the end of it
                len = (ep == 4) ? DEPTH : DEPTH + 7;
                issue(ACT_MODE, 1'b0, '0, '0, 1'b0, 1'b0);
                issue(ACT_MODE, 1'b0, '0, '0, 1'b0, 1'b1);
                send_route(cur_use_gt, len, 1'b1);
                n_sent -= len;
            end else begin
                for (int s = 0; s < 2; s++) begin
                    if ($urandom_range(0, 3) != 0) begin
                        len = ($urandom_range(0, 15) == 0) ? 1 : $urandom_range(2, 24);
                        if ($urandom_range(0, 4) == 0) begin
                            // queries land while the path is still open
                            send_route(1'(s), len, 1'b0);
                            send_queries(2);
                            issue(ACT_LOAD, 1'(s), t_coord'($urandom), t_coord'($urandom),
                                  1'b1, 1'($urandom));
                        end else begin
                            send_route(1'(s), len, 1'b1);
                        end
                    end
                end
            end
            send_queries($urandom_range(3, 12));
        end

        drain();
        repeat (DEPTH + 16) @(posedge i_clk);
        if (fail_total == 0 && pending_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* path_lookahead_point_search_top.f */
sv/plps_pkg.sv
sv/plps_ram.sv
sv/path_lookahead_point_search_top.sv
sim/plps_checker.sv
sim/testbench.sv
